FILE: src/skac_pkg.sv
// Constants and lookup functions for the soft-knee compressor.
// Holds register reset values, register indexes, curve tables and the tanh table.
// No dependencies.
package skac_pkg;

  localparam int CHANNELS_DEF = 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 4'd7;

  localparam logic [14:0] THRESHOLD_RST = 15'd3277;
  localparam logic [14:0] KNEE_RST      = 15'd18383;
  localparam logic [12:0] RATIO_RST     = 13'd1024;
  localparam logic [15:0] ATTACK_RST    = 16'd65263;
  localparam logic [15:0] RELEASE_RST   = 16'd65522;
  localparam logic [12:0] WET_RST       = 13'd436;
  localparam logic [15:0] BLEND_RST     = 16'd26214;
  localparam logic [2:0]  MODE_RST      = 3'd0;

  localparam logic [23:0] LEVEL_MAX = 24'hFFFFFF;
  localparam logic [18:0] GAIN_MAX  = 19'h3FFFF;
  localparam logic [18:0] GAIN_UNITY = 19'd65536;
  localparam logic [15:0] TANH_LAST = 16'd32746;

  // ceil(2^17 / 3): n * RECIP_3 >> 17 equals n / 3 for n below 2^16
  localparam logic [19:0] RECIP_3 = 20'd43691;

  typedef enum logic [1:0] {
    KIND_TANH = 2'd0,
    KIND_SOFT = 2'd1,
    KIND_LIN  = 2'd2
  } curve_kind_t;

  function automatic curve_kind_t mode_kind(input logic [2:0] m);
    curve_kind_t k;
    unique case (m)
      3'd2, 3'd5, 3'd7: k = KIND_SOFT;
      3'd3:             k = KIND_LIN;
      default:          k = KIND_TANH;
    endcase
    return k;
  endfunction

  function automatic logic [16:0] mode_pre(input logic [2:0] m);
    logic [16:0] v;
    unique case (m)
      3'd0: v = 17'd78643;
      3'd1: v = 17'd72090;
      3'd2: v = 17'd75366;
      3'd3: v = 17'd65536;
      3'd4: v = 17'd72090;
      3'd5: v = 17'd78643;
      3'd6: v = 17'd68813;
      default: v = 17'd81920;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] mode_post(input logic [2:0] m);
    logic [15:0] v;
    unique case (m)
      3'd0: v = 16'd58982;
      3'd1: v = 16'd62259;
      3'd2: v = 16'd60293;
      3'd3: v = 16'd64225;
      3'd4: v = 16'd60948;
      3'd5: v = 16'd59638;
      3'd6: v = 16'd62915;
      default: v = 16'd58327;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] tanh_tab(input logic [5:0] i);
    logic [15:0] v;
    unique case (i)
      6'd0:  v = 16'd0;     6'd1:  v = 16'd4075;  6'd2:  v = 16'd8025;
      6'd3:  v = 16'd11743; 6'd4:  v = 16'd15143; 6'd5:  v = 16'd18173;
      6'd6:  v = 16'd20813; 6'd7:  v = 16'd23066; 6'd8:  v = 16'd24956;
      6'd9:  v = 16'd26519; 6'd10: v = 16'd27797; 6'd11: v = 16'd28830;
      6'd12: v = 16'd29660; 6'd13: v = 16'd30322; 6'd14: v = 16'd30847;
      6'd15: v = 16'd31262; 6'd16: v = 16'd31589; 6'd17: v = 16'd31846;
      6'd18: v = 16'd32048; 6'd19: v = 16'd32206; 6'd20: v = 16'd32329;
      6'd21: v = 16'd32426; 6'd22: v = 16'd32501; 6'd23: v = 16'd32560;
      6'd24: v = 16'd32606; 6'd25: v = 16'd32642; 6'd26: v = 16'd32670;
      6'd27: v = 16'd32691; 6'd28: v = 16'd32708; 6'd29: v = 16'd32721;
      6'd30: v = 16'd32732; 6'd31: v = 16'd32740;
      default: v = 16'd32746;
    endcase
    return v;
  endfunction

endpackage

FILE: src/soft_knee_audio_compressor.sv
// The time from input acceptance to out_valid depends on the curve, on whether the gain
// division and the knee interpolation run (a zero gain skips the division), and on a
// zero knee factor, which skips the knee-start division.
// Throughput: one item at a time; in_ready is high only in the idle state, so the next
// item can be taken as soon as out_valid rises; a stalled output holds the sequencer.
// One 36x20 multiplier and one 56-bit divider are shared between the sequencer's steps.
// Reset (rst_n low, synchronous): registers to defaults, envelopes cleared, no output.
module soft_knee_audio_compressor #(
  parameter int CHANNELS = skac_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   in_sample_in,
  input  logic                                 in_channel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_sample_out,
  input  logic                                 cfg_we,
  input  logic [skac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skac_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_ENV, S_KE, S_KS, S_KSD, S_INTERP, S_INTERPD, S_NUM, S_DEN, S_GCHK,
    S_GD, S_APPLY, S_PRE, S_TANH, S_SQ, S_CUBE, S_SOFTD, S_POST, S_WET, S_MIX1,
    S_MIX2, S_DONE, S_DIV
  } state_t;

  // configuration
  logic [14:0] thr_r, knee_r;
  logic [12:0] ratio_r, wet_r;
  logic [15:0] att_r, rel_r, blend_r;
  logic [2:0]  mode_r;

  logic [23:0] env_mem [CHANNELS];

  state_t state_r, ret_r;
  logic [CH_W-1:0] ch_r;
  logic signed [15:0] x_r;
  logic [23:0] lvl_r, env_r, ks_r, ke_r;
  logic signed [14:0] ri_r;
  logic signed [39:0] num_r, den_r, acc_r, ip_r;
  logic [18:0] g_r;
  logic signed [19:0] y_r;
  logic signed [23:0] u_r, w_r, tz_r;
  logic [16:0] sa_r;
  logic [33:0] aa_r;
  logic neg_r, fin_r;
  logic signed [15:0] res_r;
  logic out_valid_r;

  // shared divider
  logic [55:0] dvd_r, q_r;
  logic [39:0] dvs_r;
  logic [40:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [40:0] rem_sh;
  logic        rem_ge;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [55:0] mul_p;

  logic [22:0] t_lvl;
  logic [12:0] reff;
  logic [23:0] diff;
  logic [23:0] mag_x;
  logic [23:0] tmag;
  logic [4:0]  t_idx;
  logic [11:0] t_fr;
  logic signed [15:0] t_d;
  logic [15:0] t_val;
  logic signed [55:0] rnd16, rnd8, rnd12;
  logic signed [24:0] et;
  logic signed [39:0] mix_sum;
  logic [23:0] ks_nxt;
  logic signed [13:0] rm;
  logic [CH_W-1:0] ch_sel;

  assign t_lvl = {thr_r, 8'b0};
  assign reff  = (ratio_r == 13'd0) ? 13'd1 : ratio_r;
  assign diff  = (lvl_r > env_r) ? (lvl_r - env_r) : (env_r - lvl_r);
  assign mag_x = in_sample_in[15] ? 24'(-32'(in_sample_in)) : 24'(in_sample_in);
  assign tmag  = tz_r[23] ? 24'(-tz_r) : 24'(tz_r);
  assign t_idx = tmag[16:12];
  assign t_fr  = tmag[11:0];
  assign t_d   = $signed(skac_pkg::tanh_tab({1'b0, t_idx} + 6'd1)) -
                 $signed(skac_pkg::tanh_tab({1'b0, t_idx}));
  assign rnd16 = mul_p + 56'sd32768;
  assign rnd8  = mul_p + 56'sd128;
  assign rnd12 = mul_p + 56'sd2048;
  assign t_val = (|tmag[23:17]) ? skac_pkg::TANH_LAST :
                 16'(skac_pkg::tanh_tab({1'b0, t_idx}) + 16'(rnd12[27:12]));
  assign et    = $signed({1'b0, env_r}) - $signed({2'b0, t_lvl});
  assign mix_sum = acc_r + mul_p[39:0] + 40'sd32768;
  assign ks_nxt = (|q_r[55:24]) ? skac_pkg::LEVEL_MAX : q_r[23:0];
  assign rm    = $signed({1'b0, reff}) - 14'sd256;
  assign ch_sel = (32'(in_channel) >= CHANNELS) ? CH_W'(CHANNELS - 1) : CH_W'(in_channel);
  assign rem_sh = {rem_r[39:0], dvd_r[55]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ENV: begin
        mul_a = $signed({12'b0, diff});
        mul_b = (lvl_r > env_r) ? $signed({4'b0, att_r}) : $signed({4'b0, rel_r});
      end
      S_KE: begin
        mul_a = $signed({13'b0, t_lvl});
        mul_b = $signed({5'b0, knee_r});
      end
      S_INTERP: begin
        mul_a = $signed({12'b0, 24'(env_r - ks_r)});
        mul_b = 20'(rm);
      end
      S_NUM: begin
        mul_a = $signed({13'b0, t_lvl});
        mul_b = 20'(ri_r);
      end
      S_DEN: begin
        mul_a = $signed({12'b0, env_r});
        mul_b = 20'(ri_r);
      end
      S_APPLY: begin
        mul_a = 36'(x_r);
        mul_b = $signed({1'b0, g_r});
      end
      S_PRE: begin
        mul_a = 36'(y_r);
        mul_b = $signed({3'b0, skac_pkg::mode_pre(mode_r)});
      end
      S_TANH: begin
        mul_a = 36'(t_d);
        mul_b = $signed({8'b0, t_fr});
      end
      S_SQ: begin
        mul_a = $signed({19'b0, sa_r});
        mul_b = $signed({3'b0, sa_r});
      end
      S_CUBE: begin
        mul_a = $signed({2'b0, aa_r});
        mul_b = $signed({3'b0, sa_r});
      end
      S_SOFTD: begin
        // divide the rounded cube by three through the reciprocal
        mul_a = $signed({20'b0, dvd_r[45:30]});
        mul_b = $signed(skac_pkg::RECIP_3);
      end
      S_POST: begin
        mul_a = 36'(u_r);
        mul_b = $signed({4'b0, skac_pkg::mode_post(mode_r)});
      end
      S_WET: begin
        mul_a = 36'(u_r);
        mul_b = $signed({7'b0, wet_r});
      end
      S_MIX1: begin
        mul_a = 36'(x_r);
        mul_b = $signed({3'b0, 17'(18'd65536 - {2'b0, blend_r})});
      end
      S_MIX2: begin
        mul_a = 36'(w_r);
        mul_b = $signed({4'b0, blend_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= skac_pkg::THRESHOLD_RST;
      knee_r  <= skac_pkg::KNEE_RST;
      ratio_r <= skac_pkg::RATIO_RST;
      att_r   <= skac_pkg::ATTACK_RST;
      rel_r   <= skac_pkg::RELEASE_RST;
      wet_r   <= skac_pkg::WET_RST;
      blend_r <= skac_pkg::BLEND_RST;
      mode_r  <= skac_pkg::MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skac_pkg::REG_THRESHOLD: thr_r   <= cfg_data[14:0];
        skac_pkg::REG_KNEE:      knee_r  <= cfg_data[14:0];
        skac_pkg::REG_RATIO:     ratio_r <= cfg_data[12:0];
        skac_pkg::REG_ATTACK:    att_r   <= cfg_data;
        skac_pkg::REG_RELEASE:   rel_r   <= cfg_data;
        skac_pkg::REG_WET:       wet_r   <= cfg_data[12:0];
        skac_pkg::REG_BLEND:     blend_r <= cfg_data;
        skac_pkg::REG_MODE:      mode_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) env_mem[i] <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            ch_r    <= ch_sel;
            lvl_r   <= {mag_x[15:0], 8'b0};
            env_r   <= env_mem[ch_sel];
            state_r <= S_ENV;
          end
        end
        S_ENV: begin
          if (lvl_r > env_r) begin
            env_r         <= lvl_r - mul_p[39:16];
            env_mem[ch_r] <= lvl_r - mul_p[39:16];
          end else begin
            env_r         <= lvl_r + mul_p[39:16];
            env_mem[ch_r] <= lvl_r + mul_p[39:16];
          end
          state_r <= S_KE;
        end
        S_KE: begin
          ke_r    <= mul_p[37:14];
          state_r <= S_KS;
        end
        S_KS: begin
          if (knee_r == 15'd0) begin
            q_r     <= {32'b0, skac_pkg::LEVEL_MAX};
            state_r <= S_KSD;
          end else begin
            dvd_r   <= {19'b0, t_lvl, 14'b0};
            dvs_r   <= {25'b0, knee_r};
            rem_r   <= '0;
            dcnt_r  <= '0;
            ret_r   <= S_KSD;
            state_r <= S_DIV;
          end
        end
        S_KSD: begin
          ks_r <= ks_nxt;
          if (env_r == 24'd0 || env_r < ks_nxt) begin
            g_r     <= skac_pkg::GAIN_UNITY;
            state_r <= S_APPLY;
          end else if (env_r > ke_r) begin
            ri_r    <= $signed({2'b0, reff});
            state_r <= S_NUM;
          end else if (ke_r > ks_nxt) begin
            state_r <= S_INTERP;
          end else begin
            ri_r    <= 15'sd256;
            state_r <= S_NUM;
          end
        end
        S_INTERP: begin
          ip_r    <= mul_p[39:0];
          dvd_r   <= mul_p[39] ? {16'b0, 40'(-mul_p[39:0])} : {16'b0, mul_p[39:0]};
          dvs_r   <= {16'b0, 24'(ke_r - ks_r)};
          rem_r   <= '0;
          dcnt_r  <= '0;
          ret_r   <= S_INTERPD;
          state_r <= S_DIV;
        end
        S_INTERPD: begin
          // truncate toward zero: negate the magnitude quotient
          ri_r    <= ip_r[39] ? 15'sd256 - $signed(q_r[14:0]) : 15'sd256 + $signed(q_r[14:0]);
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r   <= mul_p[39:0] + {{7{et[24]}}, et, 8'b0};
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r   <= mul_p[39:0];
          state_r <= S_GCHK;
        end
        S_GCHK: begin
          if (num_r <= 40'sd0 || den_r <= 40'sd0) begin
            g_r     <= '0;
            state_r <= S_APPLY;
          end else begin
            dvd_r   <= {3'b0, num_r[36:0], 16'b0};
            dvs_r   <= den_r;
            rem_r   <= '0;
            dcnt_r  <= '0;
            ret_r   <= S_GD;
            state_r <= S_DIV;
          end
        end
        S_GD: begin
          g_r     <= (q_r > 56'(skac_pkg::GAIN_MAX)) ? skac_pkg::GAIN_MAX : q_r[18:0];
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          y_r     <= rnd16[35:16];
          state_r <= S_PRE;
        end
        S_PRE: begin
          u_r  <= rnd16[39:16];
          tz_r <= rnd16[39:16];
          neg_r <= rnd16[55];
          sa_r <= rnd16[55] ?
                  ((-rnd16[55:16] > 40'sd32768) ? 17'd32768 : 17'(-rnd16[55:16])) :
                  ((rnd16[55:16] > 40'sd32768) ? 17'd32768 : 17'(rnd16[55:16]));
          fin_r <= 1'b0;
          unique case (skac_pkg::mode_kind(mode_r))
            skac_pkg::KIND_TANH: state_r <= S_TANH;
            skac_pkg::KIND_SOFT: state_r <= S_SQ;
            default:             state_r <= S_POST;
          endcase
        end
        S_TANH: begin
          u_r <= tz_r[23] ? -24'($signed({8'b0, t_val})) : 24'($signed({8'b0, t_val}));
          if (fin_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_POST;
          end
        end
        S_SQ: begin
          aa_r    <= mul_p[33:0];
          state_r <= S_CUBE;
        end
        S_CUBE: begin
          dvd_r   <= {8'b0, mul_p[47:0]} + (56'd3 << 29);
          state_r <= S_SOFTD;
        end
        S_SOFTD: begin
          u_r     <= neg_r ? -24'($signed({7'b0, 17'(sa_r - mul_p[33:17])})) :
                             24'($signed({7'b0, 17'(sa_r - mul_p[33:17])}));
          state_r <= S_POST;
        end
        S_POST: begin
          u_r     <= rnd16[39:16];
          state_r <= S_WET;
        end
        S_WET: begin
          w_r     <= rnd8[31:8];
          state_r <= S_MIX1;
        end
        S_MIX1: begin
          acc_r   <= mul_p[39:0];
          state_r <= S_MIX2;
        end
        S_MIX2: begin
          tz_r    <= mix_sum[39:16];
          fin_r   <= 1'b1;
          state_r <= S_TANH;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            res_r       <= u_r[15:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          rem_r  <= rem_ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
          q_r    <= {q_r[54:0], rem_ge};
          dvd_r  <= {dvd_r[54:0], 1'b0};
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd55) state_r <= ret_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
